@@ sv/two_level_weighted_index_sampler_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the two-level weighted index sampler
// Implication checks on the rising clock edge, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_WEIGHTED_INDEX_SAMPLER_MACROS_SVH
`define TWO_LEVEL_WEIGHTED_INDEX_SAMPLER_MACROS_SVH

`ifndef SYNTH
`define TLWS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlws check failed");
`define TLWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlws check failed");
`else
`define TLWS_ASSERT_SAME(label, clk, rst, ante, cons)
`define TLWS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ sv/tlws_pkg.sv @@
// ----------------------------------------------------------------------------
// tlws_pkg
// Field widths, codes and default sizes shared by the sampler files.
// ----------------------------------------------------------------------------
package tlws_pkg;

  localparam int ACTION_W      = 2;
  localparam int WEIGHT_W      = 32;
  localparam int RAND_W        = 32;
  localparam int BAND_IDX_W    = 4;
  localparam int PIXEL_IDX_W   = 12;
  localparam int STATUS_W      = 2;

  localparam int BAND_COUNT_W  = 5;
  localparam int PIXEL_COUNT_W = 13;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_INDEX_W   = 2;

  localparam int DEF_MAX_BANDS   = 16;
  localparam int DEF_MAX_PIXELS  = 4096;
  localparam int DEF_WEIGHT_BITS = 32;

  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PARTIAL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_BAND_COUNT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_COUNT = 2'd1;

  localparam logic [BAND_COUNT_W-1:0]  BAND_COUNT_RST  = 5'd1;
  localparam logic [PIXEL_COUNT_W-1:0] PIXEL_COUNT_RST = 13'd4096;

endpackage

@@ sv/tlws_in_if.sv @@
// ----------------------------------------------------------------------------
// tlws_in_if
// Request channel: action word with weight and two random fractions.
// ----------------------------------------------------------------------------
interface tlws_in_if;

  logic                               valid;
  logic                               ready;
  logic [tlws_pkg::ACTION_W-1:0]      action;
  logic [tlws_pkg::WEIGHT_W-1:0]      weight;
  logic [tlws_pkg::RAND_W-1:0]        rand_band;
  logic [tlws_pkg::RAND_W-1:0]        rand_pixel;

  modport source (output valid, action, weight, rand_band, rand_pixel, input ready);
  modport sink   (input valid, action, weight, rand_band, rand_pixel, output ready);

endinterface

@@ sv/tlws_out_if.sv @@
// ----------------------------------------------------------------------------
// tlws_out_if
// Result channel: chosen band and pixel with a status code.
// ----------------------------------------------------------------------------
interface tlws_out_if;

  logic                               valid;
  logic                               ready;
  logic [tlws_pkg::BAND_IDX_W-1:0]    band_choice;
  logic [tlws_pkg::PIXEL_IDX_W-1:0]   pixel_index;
  logic [tlws_pkg::STATUS_W-1:0]      status;

  modport source (output valid, band_choice, pixel_index, status, input ready);
  modport sink   (input valid, band_choice, pixel_index, status, output ready);

endinterface

@@ sv/two_level_weighted_index_sampler.sv @@
// ----------------------------------------------------------------------------
// two_level_weighted_index_sampler
// Builds per-band and cross-band cumulative weight tables from load words and
// draws a band and a pixel by two upper-bound searches on sample words.
// ----------------------------------------------------------------------------
// Usage
//   req carries one word per action: clear, load (weight) or sample
//   (rand_band, rand_pixel). rsp carries one word per sample: band_choice,
//   pixel_index, status. cfg_wr_en/cfg_index/cfg_data write band_count (0)
//   and pixel_count (1); each write to either also clears the table.
//   A sample on an incomplete table or a zero total skips the scalings and
//   both searches. A full sample searches the bands, then the pixels of the
//   chosen band; each search step is bound by the single read port of each
//   table memory, and the two scalings share one 32x32 multiplier.
//   Reset (rst, synchronous) empties the table and restores band_count 1 and
//   pixel_count 4096; no memory sweep is needed.
//   A finished result waits in the output register while rsp.ready is low;
//   req stays ready meanwhile, and only a second sample waits for it.
// ----------------------------------------------------------------------------
`include "two_level_weighted_index_sampler_macros.svh"

module two_level_weighted_index_sampler #(
  parameter int MAX_BANDS   = tlws_pkg::DEF_MAX_BANDS,
  parameter int MAX_PIXELS  = tlws_pkg::DEF_MAX_PIXELS,
  parameter int WEIGHT_BITS = tlws_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [tlws_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tlws_pkg::CFG_DATA_W-1:0]     cfg_data,
  tlws_in_if.sink                             req,
  tlws_out_if.source                          rsp
);

  localparam int BIDX_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int PIDX_W = $clog2(MAX_PIXELS);
  localparam int SIDX_W = (BIDX_W > PIDX_W) ? BIDX_W : PIDX_W;
  localparam int BCNT_W = $clog2(MAX_BANDS + 1);
  localparam int PCNT_W = $clog2(MAX_PIXELS + 1);
  localparam int DEPTH  = MAX_BANDS * MAX_PIXELS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PSUM_W = (WEIGHT_BITS + PIDX_W > 64) ? 64 : WEIGHT_BITS + PIDX_W;
  localparam int BSUM_W = (PSUM_W + $clog2(MAX_BANDS) > 64) ? 64 :
                          PSUM_W + $clog2(MAX_BANDS);
  localparam int WIN_W  = (WEIGHT_BITS < tlws_pkg::WEIGHT_W) ? WEIGHT_BITS :
                          tlws_pkg::WEIGHT_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MLO   = 9'b000000010,
    S_MHI   = 9'b000000100,
    S_ADD   = 9'b000001000,
    S_SRCH  = 9'b000010000,
    S_BASE  = 9'b000100000,
    S_BTOT  = 9'b001000000,
    S_BTOTW = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  logic [tlws_pkg::BAND_COUNT_W-1:0]  band_count;
  logic [tlws_pkg::PIXEL_COUNT_W-1:0] pixel_count;
  logic [BCNT_W-1:0] nb_eff;
  logic [PCNT_W-1:0] np_eff;

  logic [BCNT_W-1:0] load_band;
  logic [PCNT_W-1:0] load_pixel;
  logic [ADDR_W-1:0] load_addr;
  logic [ADDR_W-1:0] band_base;
  logic [PSUM_W-1:0] running;
  logic [BSUM_W-1:0] band_acc;
  logic              table_full;

  logic [PSUM_W-1:0] pix_mem [DEPTH];
  logic [BSUM_W-1:0] band_mem [MAX_BANDS];
  logic [PSUM_W-1:0] pix_rdata;
  logic [BSUM_W-1:0] band_rdata;
  logic [ADDR_W-1:0] pix_raddr;
  logic [BIDX_W-1:0] band_raddr;

  logic [tlws_pkg::RAND_W-1:0] rand_band_r;
  logic [tlws_pkg::RAND_W-1:0] rand_pixel_r;
  logic              phase_band;
  logic [63:0]       scale_total;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       mul_p;
  logic [63:0]       prod;
  logic [31:0]       prod_sh;
  logic [BSUM_W-1:0] target;

  logic [SIDX_W-1:0] s_lo;
  logic [SIDX_W-1:0] s_hi;
  logic [SIDX_W-1:0] s_mid;
  logic [SIDX_W-1:0] hmax;
  logic [SIDX_W-1:0] mid0;
  logic [SIDX_W-1:0] mid_up;
  logic [SIDX_W-1:0] mid_dn;
  logic              done_up;
  logic              done_dn;
  logic [BSUM_W-1:0] cmp_data;
  logic              le;
  logic [SIDX_W-1:0] sel_mid;
  logic [ADDR_W-1:0] base_m1;
  logic [BIDX_W-1:0] band_sel;

  logic [tlws_pkg::STATUS_W-1:0]    res_status;
  logic                             out_valid;
  logic [tlws_pkg::BAND_IDX_W-1:0]  out_band;
  logic [tlws_pkg::PIXEL_IDX_W-1:0] out_pixel;
  logic [tlws_pkg::STATUS_W-1:0]    out_status;

  logic              in_fire;
  logic              load_fire;
  logic              last_pix;
  logic [PSUM_W-1:0] run_next;
  logic [BSUM_W-1:0] band_sum_next;
  logic              out_free;

  assign req.ready       = (state == S_IDLE);
  assign in_fire         = req.valid && req.ready;
  assign load_fire       = in_fire && (req.action == tlws_pkg::ACT_LOAD) && !table_full;
  assign run_next        = running + PSUM_W'(req.weight[WIN_W-1:0]);
  assign band_sum_next   = band_acc + BSUM_W'(run_next);
  assign last_pix        = ((load_pixel + PCNT_W'(1)) >= np_eff);
  assign out_free        = !out_valid || rsp.ready;

  assign rsp.valid       = out_valid;
  assign rsp.band_choice = out_band;
  assign rsp.pixel_index = out_pixel;
  assign rsp.status      = out_status;

  always_comb begin
    if (band_count == '0) begin
      nb_eff = BCNT_W'(1);
    end else if (32'(band_count) > MAX_BANDS) begin
      nb_eff = BCNT_W'(MAX_BANDS);
    end else begin
      nb_eff = BCNT_W'(band_count);
    end
    if (pixel_count == '0) begin
      np_eff = PCNT_W'(1);
    end else if (32'(pixel_count) > MAX_PIXELS) begin
      np_eff = PCNT_W'(MAX_PIXELS);
    end else begin
      np_eff = PCNT_W'(pixel_count);
    end
  end

  // shared multiplier: fraction times one 32-bit half of the total
  assign mul_a = phase_band ? rand_band_r : rand_pixel_r;
  assign mul_b = (state == S_MLO) ? scale_total[31:0] : scale_total[63:32];
  assign mul_p = mul_a * mul_b;

  // search step candidates for both compare outcomes
  assign hmax     = phase_band ? SIDX_W'(nb_eff - BCNT_W'(1)) : SIDX_W'(np_eff - PCNT_W'(1));
  assign mid0     = SIDX_W'(({1'b0, hmax} + (SIDX_W+1)'(1)) >> 1);
  assign mid_up   = SIDX_W'(({1'b0, s_mid} + {1'b0, s_hi} + (SIDX_W+1)'(1)) >> 1);
  assign mid_dn   = SIDX_W'(({1'b0, s_lo} + {1'b0, s_mid}) >> 1);
  assign done_up  = !(s_mid < s_hi);
  assign done_dn  = !(({1'b0, s_lo} + (SIDX_W+1)'(1)) < {1'b0, s_mid});
  assign cmp_data = phase_band ? band_rdata : BSUM_W'(pix_rdata);
  assign le       = (cmp_data <= target);

  always_comb begin
    sel_mid    = mid0;
    pix_raddr  = base_m1 + ADDR_W'(mid0);
    band_raddr = BIDX_W'(mid0 - SIDX_W'(1));
    case (state)
      S_SRCH: begin
        sel_mid    = le ? mid_up : mid_dn;
        pix_raddr  = le ? (base_m1 + ADDR_W'(mid_up)) : (base_m1 + ADDR_W'(mid_dn));
        band_raddr = le ? BIDX_W'(mid_up - SIDX_W'(1)) : BIDX_W'(mid_dn - SIDX_W'(1));
      end
      S_BTOT: begin
        pix_raddr = base_m1 + ADDR_W'(np_eff);
      end
      default: begin
        sel_mid = mid0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      pix_mem[load_addr] <= run_next;
      if (last_pix) begin
        band_mem[BIDX_W'(load_band)] <= band_sum_next;
      end
    end
    pix_rdata  <= pix_mem[pix_raddr];
    band_rdata <= band_mem[band_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band_count  <= tlws_pkg::BAND_COUNT_RST;
      pixel_count <= tlws_pkg::PIXEL_COUNT_RST;
      load_band   <= '0;
      load_pixel  <= '0;
      load_addr   <= '0;
      band_base   <= '0;
      running     <= '0;
      band_acc    <= '0;
      table_full  <= 1'b0;
    end else if (cfg_wr_en) begin
      if (cfg_index == tlws_pkg::REG_BAND_COUNT) begin
        band_count <= cfg_data[tlws_pkg::BAND_COUNT_W-1:0];
      end
      if (cfg_index == tlws_pkg::REG_BAND_COUNT || cfg_index == tlws_pkg::REG_PIXEL_COUNT) begin
        load_band  <= '0;
        load_pixel <= '0;
        load_addr  <= '0;
        band_base  <= '0;
        running    <= '0;
        band_acc   <= '0;
        table_full <= 1'b0;
      end
      if (cfg_index == tlws_pkg::REG_PIXEL_COUNT) begin
        pixel_count <= cfg_data[tlws_pkg::PIXEL_COUNT_W-1:0];
      end
    end else if (in_fire && req.action == tlws_pkg::ACT_CLEAR) begin
      load_band  <= '0;
      load_pixel <= '0;
      load_addr  <= '0;
      band_base  <= '0;
      running    <= '0;
      band_acc   <= '0;
      table_full <= 1'b0;
    end else if (load_fire) begin
      if (last_pix) begin
        band_acc   <= band_sum_next;
        running    <= '0;
        load_pixel <= '0;
        load_band  <= load_band + BCNT_W'(1);
        band_base  <= band_base + ADDR_W'(MAX_PIXELS);
        load_addr  <= band_base + ADDR_W'(MAX_PIXELS);
        if ((load_band + BCNT_W'(1)) >= nb_eff) begin
          table_full <= 1'b1;
        end
      end else begin
        running    <= run_next;
        load_pixel <= load_pixel + PCNT_W'(1);
        load_addr  <= load_addr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      phase_band <= 1'b1;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire && req.action == tlws_pkg::ACT_SAMPLE) begin
            rand_band_r  <= req.rand_band;
            rand_pixel_r <= req.rand_pixel;
            phase_band   <= 1'b1;
            scale_total  <= 64'(band_acc);
            band_sel     <= '0;
            s_lo         <= '0;
            if (!table_full) begin
              res_status <= tlws_pkg::ST_PARTIAL;
              state      <= S_DONE;
            end else if (band_acc == '0) begin
              res_status <= tlws_pkg::ST_ZERO;
              state      <= S_DONE;
            end else begin
              res_status <= tlws_pkg::ST_OK;
              state      <= S_MLO;
            end
          end
        end
        S_MLO: begin
          prod  <= mul_p;
          state <= S_MHI;
        end
        S_MHI: begin
          prod_sh <= prod[63:32];
          prod    <= mul_p;
          state   <= S_ADD;
        end
        S_ADD: begin
          target <= BSUM_W'(prod + 64'(prod_sh));
          s_lo   <= '0;
          s_hi   <= hmax;
          s_mid  <= mid0;
          if (hmax == '0) begin
            state <= phase_band ? S_BASE : S_DONE;
          end else begin
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          s_lo  <= le ? s_mid : s_lo;
          s_hi  <= le ? s_hi : (s_mid - SIDX_W'(1));
          s_mid <= sel_mid;
          if (le ? done_up : done_dn) begin
            state <= phase_band ? S_BASE : S_DONE;
          end
        end
        S_BASE: begin
          band_sel <= BIDX_W'(s_lo);
          base_m1  <= ADDR_W'(32'(s_lo) * MAX_PIXELS) - ADDR_W'(1);
          state    <= S_BTOT;
        end
        S_BTOT: begin
          state <= S_BTOTW;
        end
        S_BTOTW: begin
          scale_total <= 64'(pix_rdata);
          phase_band  <= 1'b0;
          state       <= S_MLO;
        end
        S_DONE: begin
          if (out_free) begin
            out_band   <= tlws_pkg::BAND_IDX_W'(band_sel);
            out_pixel  <= tlws_pkg::PIXEL_IDX_W'(s_lo);
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TLWS_ASSERT_SAME(a_fail_zero_idx, clk, rst, rsp.valid && rsp.status != tlws_pkg::ST_OK, rsp.band_choice == '0 && rsp.pixel_index == '0)
  `TLWS_ASSERT_SAME(a_full_at_end, clk, rst, table_full, load_band == nb_eff && load_pixel == '0)
  `TLWS_ASSERT_SAME(a_fill_in_band, clk, rst, !table_full, load_pixel < np_eff && load_band < nb_eff)
  `TLWS_ASSERT_NEXT(a_partial_fast, clk, rst, in_fire && req.action == tlws_pkg::ACT_SAMPLE && !table_full, state == S_DONE && res_status == tlws_pkg::ST_PARTIAL)

endmodule
